FILE: hdl/sacs_pkg.sv
// Shared types, constants and codes of the stick average and channel scale block.
package sacs_pkg;

  localparam int RAW_BITS     = 12;
  localparam int CHAN_BITS    = 11;
  localparam int STICK_FIELDS = 5;
  localparam int FULL_SCALE   = (1 << RAW_BITS) - 1;

  localparam int WINDOW_LEN_DEF  = 8;
  localparam int SAMPLE_BITS_DEF = 12;
  localparam int NUM_STICKS_DEF  = 5;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] CFG_ADC_MIN  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_ADC_MAX  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_CHAN_MIN = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_CHAN_MAX = CFG_IDX_W'(3);

  localparam logic [RAW_BITS-1:0]  ADC_MIN_RST  = RAW_BITS'(0);
  localparam logic [RAW_BITS-1:0]  ADC_MAX_RST  = RAW_BITS'(4095);
  localparam logic [CHAN_BITS-1:0] CHAN_MIN_RST = CHAN_BITS'(172);
  localparam logic [CHAN_BITS-1:0] CHAN_MAX_RST = CHAN_BITS'(1811);

  typedef struct packed {
    logic [RAW_BITS-1:0] aileron_raw;
    logic [RAW_BITS-1:0] elevator_raw;
    logic [RAW_BITS-1:0] throttle_raw;
    logic [RAW_BITS-1:0] flap_raw;
    logic [RAW_BITS-1:0] rudder_raw;
    logic                switch_one;
    logic                switch_two;
  } in_item_t;

  typedef struct packed {
    logic [CHAN_BITS-1:0] aileron_chan;
    logic [CHAN_BITS-1:0] elevator_chan;
    logic [CHAN_BITS-1:0] throttle_chan;
    logic [CHAN_BITS-1:0] flap_chan;
    logic [CHAN_BITS-1:0] rudder_chan;
    logic [CHAN_BITS-1:0] aux_one_chan;
    logic [CHAN_BITS-1:0] aux_two_chan;
  } out_item_t;

  typedef struct packed {
    logic [RAW_BITS-1:0]  adc_min;
    logic [RAW_BITS-1:0]  adc_max;
    logic [CHAN_BITS-1:0] chan_min;
    logic [CHAN_BITS-1:0] chan_max;
  } cfg_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_READ,
    OP_SUM,
    OP_AVG_MUL,
    OP_AVG_FIX,
    OP_ONE_MUL,
    OP_DIV_EST,
    OP_ONE_FIX,
    OP_TWO_MUL,
    OP_TWO_FIX,
    OP_FINISH
  } dp_op_t;

  typedef struct packed {
    logic last_stick;
    logic out_free;
  } dp_status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_SUM,
    ST_AVG_MUL,
    ST_AVG_FIX,
    ST_ONE_MUL,
    ST_EST_ONE,
    ST_ONE_FIX,
    ST_TWO_MUL,
    ST_EST_TWO,
    ST_TWO_FIX,
    ST_DONE
  } ctrl_state_t;

endpackage

FILE: hdl/stick_average_and_channel_scale_top.sv
// Top level of the stick average and channel scale block.
// A request on the input channel is one converter scan: five stick samples and
// two switch levels, taken when in_valid is high and in_stall is low. Each stick
// sample enters its own window, the window sum is averaged, and the average goes
// through the converter range scaling and then the channel range scaling.
// One result request follows each scan on the output channel, taken when
// out_valid is high and out_stall is low. The four range registers are to be
// written through the cfg_ port, which is always ready, while the block is idle;
// the block itself does not enforce this. The single multiply and divide path
// serves each stick in turn for ten steps, and a new scan is accepted only
// after the last stick of the previous scan is finished. The output register
// holds a finished result while out_stall is high; the block then waits after
// its last stick and keeps in_stall high until the result register can take
// the new result.
// Synchronous reset clears the windows, the running sums, the slot pointer and
// the output valid, and loads the range registers with their defaults.
module stick_average_and_channel_scale_top #(
  parameter int WINDOW_LEN  = sacs_pkg::WINDOW_LEN_DEF,
  parameter int SAMPLE_BITS = sacs_pkg::SAMPLE_BITS_DEF,
  parameter int NUM_STICKS  = sacs_pkg::NUM_STICKS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  sacs_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output sacs_pkg::out_item_t             out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [sacs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sacs_pkg::CFG_DATA_W-1:0] cfg_data
);
  import sacs_pkg::*;

  cfg_t       cfg_w;
  dp_op_t     op_w;
  dp_status_t status_w;

  sacs_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_ready (cfg_ready),
    .cfg       (cfg_w)
  );

  sacs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status_w),
    .op       (op_w)
  );

  sacs_dp #(
    .WINDOW_LEN  (WINDOW_LEN),
    .SAMPLE_BITS (SAMPLE_BITS),
    .NUM_STICKS  (NUM_STICKS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .op        (op_w),
    .in_data   (in_data),
    .cfg       (cfg_w),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .status    (status_w)
  );

  a_busy_after_accept : assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("block did not go busy after accepting a scan");

  a_result_from_finish : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(op_w == OP_FINISH))
    else $error("result appeared without a finish step");

  a_idle_after_finish : assert property (@(posedge clk) disable iff (!rst_n)
    (op_w == OP_FINISH) |=> !in_stall)
    else $error("block not ready for a new scan after finishing");

endmodule

FILE: hdl/sacs_cfg.sv
// Configuration register file holding the two scaling ranges.
module sacs_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  input  logic [sacs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sacs_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                           cfg_ready,
  output sacs_pkg::cfg_t                 cfg
);
  import sacs_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_ADC_MIN:  cfg_nxt.adc_min  = cfg_data[RAW_BITS-1:0];
        CFG_ADC_MAX:  cfg_nxt.adc_max  = cfg_data[RAW_BITS-1:0];
        CFG_CHAN_MIN: cfg_nxt.chan_min = cfg_data[CHAN_BITS-1:0];
        CFG_CHAN_MAX: cfg_nxt.chan_max = cfg_data[CHAN_BITS-1:0];
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.adc_min  <= ADC_MIN_RST;
      cfg_r.adc_max  <= ADC_MAX_RST;
      cfg_r.chan_min <= CHAN_MIN_RST;
      cfg_r.chan_max <= CHAN_MAX_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

FILE: hdl/sacs_ctrl.sv
// Controller state machine that sequences each stick through the shared datapath.
module sacs_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  sacs_pkg::dp_status_t   status,
  output sacs_pkg::dp_op_t       op
);
  import sacs_pkg::*;

  ctrl_state_t state_r;
  ctrl_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    op        = OP_NONE;
    in_stall  = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = !rst_n;
        if (in_valid && rst_n) begin
          op        = OP_LOAD;
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        op        = OP_READ;
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        op        = OP_SUM;
        state_nxt = ST_AVG_MUL;
      end
      ST_AVG_MUL: begin
        op        = OP_AVG_MUL;
        state_nxt = ST_AVG_FIX;
      end
      ST_AVG_FIX: begin
        op        = OP_AVG_FIX;
        state_nxt = ST_ONE_MUL;
      end
      ST_ONE_MUL: begin
        op        = OP_ONE_MUL;
        state_nxt = ST_EST_ONE;
      end
      ST_EST_ONE: begin
        op        = OP_DIV_EST;
        state_nxt = ST_ONE_FIX;
      end
      ST_ONE_FIX: begin
        op        = OP_ONE_FIX;
        state_nxt = ST_TWO_MUL;
      end
      ST_TWO_MUL: begin
        op        = OP_TWO_MUL;
        state_nxt = ST_EST_TWO;
      end
      ST_EST_TWO: begin
        op        = OP_DIV_EST;
        state_nxt = ST_TWO_FIX;
      end
      ST_TWO_FIX: begin
        op        = OP_TWO_FIX;
        state_nxt = status.last_stick ? ST_DONE : ST_READ;
      end
      ST_DONE: begin
        if (status.out_free) begin
          op        = OP_FINISH;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: hdl/sacs_dp.sv
// Datapath with the sample windows, running sums, shared product register and output register.
module sacs_dp #(
  parameter int WINDOW_LEN  = sacs_pkg::WINDOW_LEN_DEF,
  parameter int SAMPLE_BITS = sacs_pkg::SAMPLE_BITS_DEF,
  parameter int NUM_STICKS  = sacs_pkg::NUM_STICKS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  sacs_pkg::dp_op_t      op,
  input  sacs_pkg::in_item_t    in_data,
  input  sacs_pkg::cfg_t        cfg,
  input  logic                  out_stall,
  output logic                  out_valid,
  output sacs_pkg::out_item_t   out_data,
  output sacs_pkg::dp_status_t  status
);
  import sacs_pkg::*;

  localparam int SW     = (SAMPLE_BITS < RAW_BITS) ? SAMPLE_BITS : RAW_BITS;
  localparam int ACTIVE = (NUM_STICKS < STICK_FIELDS) ? NUM_STICKS : STICK_FIELDS;
  localparam int SUM_W  = SW + $clog2(WINDOW_LEN);
  localparam int PROD_W = (2 * SUM_W > 2 * RAW_BITS) ? 2 * SUM_W : 2 * RAW_BITS;
  localparam int SLOT_W = $clog2(WINDOW_LEN);
  localparam int STK_W  = (ACTIVE > 1) ? $clog2(ACTIVE) : 1;
  localparam int DEPTH  = ACTIVE * WINDOW_LEN;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int DW     = 2 * RAW_BITS + 2;
  localparam logic [SUM_W-1:0] RECIP = SUM_W'((2 ** SUM_W) / WINDOW_LEN);

  in_item_t             item_r;
  logic [SLOT_W-1:0]    slot_r;
  logic [STK_W-1:0]     stick_r;
  logic [SW-1:0]        mem [DEPTH];
  logic [DEPTH-1:0]     vld_r;
  logic [SW-1:0]        rd_r;
  logic                 rd_vld_r;
  logic [SUM_W-1:0]     sums_r [ACTIVE];
  logic [SUM_W-1:0]     acc_r;
  logic [PROD_W-1:0]    prod_r;
  logic [RAW_BITS:0]    qe_r;
  logic [SW-1:0]        avg_r;
  logic [RAW_BITS-1:0]  val_r;
  logic [CHAN_BITS-1:0] res_r [STICK_FIELDS];
  out_item_t            out_r;
  logic                 out_valid_r;

  logic [ADDR_W-1:0]          addr_w;
  logic [RAW_BITS-1:0]        raw_w;
  logic [SW-1:0]              samp_w;
  logic [SW-1:0]              old_w;
  logic [SUM_W-1:0]           sum_nxt;
  logic [2*SUM_W-1:0]         m_avg_w;
  logic [SUM_W-1:0]           qa_w;
  logic [SUM_W-1:0]           ra_w;
  logic [SUM_W-1:0]           avg_nxt;
  logic [RAW_BITS:0]          span1_w;
  logic                       neg1_w;
  logic [RAW_BITS-1:0]        mag1_w;
  logic [SW+RAW_BITS-1:0]     m_one_w;
  logic [CHAN_BITS-1:0]       span2_w;
  logic                       inv2_w;
  logic [RAW_BITS+CHAN_BITS-1:0] m_two_w;
  logic [2*RAW_BITS-1:0]      pd_w;
  logic [2*RAW_BITS:0]        qe_nxt;
  logic [DW-1:0]              rem_w;
  logic [RAW_BITS:0]          q_w;
  logic [RAW_BITS:0]          v1_w;
  logic [CHAN_BITS-1:0]       c2_w;
  out_item_t                  out_nxt;

  assign addr_w = ADDR_W'(stick_r) * ADDR_W'(WINDOW_LEN) + ADDR_W'(slot_r);

  always_comb begin
    case (int'(stick_r))
      0:       raw_w = item_r.aileron_raw;
      1:       raw_w = item_r.elevator_raw;
      2:       raw_w = item_r.throttle_raw;
      3:       raw_w = item_r.flap_raw;
      4:       raw_w = item_r.rudder_raw;
      default: raw_w = '0;
    endcase
  end

  assign samp_w  = raw_w[SW-1:0];
  assign old_w   = rd_vld_r ? rd_r : '0;
  assign sum_nxt = sums_r[stick_r] - SUM_W'(old_w) + SUM_W'(samp_w);

  // Division by the window length is a reciprocal multiply followed by one correction.
  assign m_avg_w = acc_r * RECIP;
  assign qa_w    = prod_r[2*SUM_W-1:SUM_W];
  assign ra_w    = acc_r - SUM_W'(qa_w * SUM_W'(WINDOW_LEN));
  assign avg_nxt = (ra_w >= SUM_W'(WINDOW_LEN)) ? qa_w + SUM_W'(1) : qa_w;

  assign span1_w = {1'b0, cfg.adc_max} - {1'b0, cfg.adc_min};
  assign neg1_w  = span1_w[RAW_BITS];
  assign mag1_w  = neg1_w ? RAW_BITS'(-span1_w) : span1_w[RAW_BITS-1:0];
  assign m_one_w = avg_r * mag1_w;

  assign span2_w = cfg.chan_max - cfg.chan_min;
  assign inv2_w  = cfg.chan_max < cfg.chan_min;
  assign m_two_w = val_r * span2_w;

  // Division by full scale: the estimate is low by at most one, fixed by a remainder check.
  assign pd_w   = prod_r[2*RAW_BITS-1:0];
  assign qe_nxt = {1'b0, pd_w} + (2*RAW_BITS+1)'(pd_w >> RAW_BITS);
  assign rem_w  = DW'(pd_w) + DW'(qe_r) - (DW'(qe_r) << RAW_BITS);
  assign q_w    = (rem_w >= DW'(FULL_SCALE)) ? qe_r + (RAW_BITS+1)'(1) : qe_r;

  assign v1_w = neg1_w ? {1'b0, cfg.adc_min} - q_w : {1'b0, cfg.adc_min} + q_w;
  assign c2_w = inv2_w ? cfg.chan_min : cfg.chan_min + q_w[CHAN_BITS-1:0];

  always_comb begin
    out_nxt.aileron_chan  = res_r[0];
    out_nxt.elevator_chan = (ACTIVE > 1) ? res_r[1] : '0;
    out_nxt.throttle_chan = (ACTIVE > 2) ? res_r[2] : '0;
    out_nxt.flap_chan     = (ACTIVE > 3) ? res_r[3] : '0;
    out_nxt.rudder_chan   = (ACTIVE > 4) ? res_r[4] : '0;
    out_nxt.aux_one_chan  = item_r.switch_one ? cfg.chan_max : cfg.chan_min;
    out_nxt.aux_two_chan  = item_r.switch_two ? cfg.chan_max : cfg.chan_min;
  end

  assign status.last_stick = (int'(stick_r) == ACTIVE - 1);
  assign status.out_free   = !out_valid_r || !out_stall;
  assign out_valid         = out_valid_r;
  assign out_data          = out_r;

  always_ff @(posedge clk) begin
    if (op == OP_SUM) begin
      mem[addr_w] <= samp_w;
    end
    if (op == OP_READ) begin
      rd_r <= mem[addr_w];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
      slot_r   <= '0;
      stick_r  <= '0;
      for (int i = 0; i < ACTIVE; i++) begin
        sums_r[i] <= '0;
      end
      out_valid_r <= 1'b0;
    end else begin
      if (op == OP_READ) begin
        rd_vld_r <= vld_r[addr_w];
      end
      if (op == OP_SUM) begin
        vld_r[addr_w]   <= 1'b1;
        sums_r[stick_r] <= sum_nxt;
      end
      if (op == OP_LOAD) begin
        stick_r <= '0;
      end else if (op == OP_TWO_FIX) begin
        stick_r <= status.last_stick ? '0 : stick_r + STK_W'(1);
      end
      if (op == OP_FINISH) begin
        slot_r      <= (int'(slot_r) == WINDOW_LEN - 1) ? '0 : slot_r + SLOT_W'(1);
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (op)
      OP_LOAD:    item_r <= in_data;
      OP_SUM:     acc_r <= sum_nxt;
      OP_AVG_MUL: prod_r <= PROD_W'(m_avg_w);
      OP_AVG_FIX: avg_r <= avg_nxt[SW-1:0];
      OP_ONE_MUL: prod_r <= PROD_W'(m_one_w);
      OP_DIV_EST: qe_r <= qe_nxt[2*RAW_BITS:RAW_BITS];
      OP_ONE_FIX: val_r <= v1_w[RAW_BITS-1:0];
      OP_TWO_MUL: prod_r <= PROD_W'(m_two_w);
      OP_TWO_FIX: res_r[stick_r] <= c2_w;
      OP_FINISH:  out_r <= out_nxt;
      default:    ;
    endcase
  end

endmodule

FILE: bench/stick_average_and_channel_scale_checker.sv
// Checker that predicts the channel values of each scan and compares them with the block's results.
`timescale 1ns / 100ps
module stick_average_and_channel_scale_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  sacs_pkg::in_item_t              in_data,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  sacs_pkg::out_item_t             out_data,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [sacs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sacs_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              fault_count,
  output int                              due_count
);
  import sacs_pkg::*;

  localparam int SUM_BITS = RAW_BITS + $clog2(WINDOW_LEN_DEF);

  logic [RAW_BITS-1:0] stick_history [STICK_FIELDS][WINDOW_LEN_DEF];
  logic [SUM_BITS-1:0] stick_sum [STICK_FIELDS];
  int                  slot;
  cfg_t                ranges;
  out_item_t           channels_due [$];
  int                  faults = 0;
  int                  due = 0;

  assign fault_count = faults;
  assign due_count   = due;

  function automatic logic [CHAN_BITS-1:0] scale_stick(input logic [RAW_BITS-1:0] avg);
    int          span;
    int          level;
    int unsigned scaled;
    span  = int'(ranges.adc_max) - int'(ranges.adc_min);
    level = int'(avg) * span / FULL_SCALE + int'(ranges.adc_min);
    if (level < 0) level = 0;
    if (level > FULL_SCALE) level = FULL_SCALE;
    if (ranges.chan_max < ranges.chan_min) return ranges.chan_min;
    scaled = level;
    scaled = scaled * (ranges.chan_max - ranges.chan_min) / FULL_SCALE + ranges.chan_min;
    return CHAN_BITS'(scaled);
  endfunction

  function automatic out_item_t scan_to_channels(input in_item_t scan);
    logic [RAW_BITS-1:0]  raw [STICK_FIELDS];
    logic [CHAN_BITS-1:0] chan [STICK_FIELDS];
    out_item_t            res;
    raw = '{scan.aileron_raw, scan.elevator_raw, scan.throttle_raw, scan.flap_raw,
            scan.rudder_raw};
    for (int k = 0; k < STICK_FIELDS; k++) begin
      chan[k] = '0;
      if (k < NUM_STICKS_DEF) begin
        stick_sum[k] = stick_sum[k] - SUM_BITS'(stick_history[k][slot]) + SUM_BITS'(raw[k]);
        stick_history[k][slot] = raw[k];
        chan[k] = scale_stick(RAW_BITS'(stick_sum[k] / WINDOW_LEN_DEF));
      end
    end
    slot = (slot + 1) % WINDOW_LEN_DEF;
    res = '{chan[0], chan[1], chan[2], chan[3], chan[4],
            scan.switch_one ? ranges.chan_max : ranges.chan_min,
            scan.switch_two ? ranges.chan_max : ranges.chan_min};
    return res;
  endfunction

  task automatic check_chan(input string field, input logic [CHAN_BITS-1:0] want,
                            input logic [CHAN_BITS-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      faults++;
    end
  endtask

  always @(posedge clk) begin : watch
    out_item_t want;
    if (!rst_n) begin
      for (int k = 0; k < STICK_FIELDS; k++) begin
        stick_sum[k] = '0;
        for (int j = 0; j < WINDOW_LEN_DEF; j++) stick_history[k][j] = '0;
      end
      slot   = 0;
      ranges = '{ADC_MIN_RST, ADC_MAX_RST, CHAN_MIN_RST, CHAN_MAX_RST};
      channels_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_ADC_MIN:  ranges.adc_min  = cfg_data[RAW_BITS-1:0];
          CFG_ADC_MAX:  ranges.adc_max  = cfg_data[RAW_BITS-1:0];
          CFG_CHAN_MIN: ranges.chan_min = cfg_data[CHAN_BITS-1:0];
          CFG_CHAN_MAX: ranges.chan_max = cfg_data[CHAN_BITS-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) channels_due.push_back(scan_to_channels(in_data));
      if (out_valid && !out_stall) begin
        if (channels_due.size() == 0) begin
          $error("result request with no scan outstanding: %h", out_data);
          faults++;
        end else begin
          want = channels_due.pop_front();
          check_chan("aileron_chan", want.aileron_chan, out_data.aileron_chan);
          check_chan("elevator_chan", want.elevator_chan, out_data.elevator_chan);
          check_chan("throttle_chan", want.throttle_chan, out_data.throttle_chan);
          check_chan("flap_chan", want.flap_chan, out_data.flap_chan);
          check_chan("rudder_chan", want.rudder_chan, out_data.rudder_chan);
          check_chan("aux_one_chan", want.aux_one_chan, out_data.aux_one_chan);
          check_chan("aux_two_chan", want.aux_two_chan, out_data.aux_two_chan);
        end
      end
    end
    due = channels_due.size();
  end

endmodule

FILE: bench/stick_average_and_channel_scale_top_tb.sv
// Testbench top for the stick average and channel scale block: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module stick_average_and_channel_scale_top_tb;
  import sacs_pkg::*;

  localparam int QUIET_LIMIT   = 3000;
  localparam int MAX_GAP       = 3;
  localparam int PHASES        = 10;
  localparam int PHASE_SCANS   = 80;
  localparam int STEADY_SCANS  = 16;
  localparam int LONG_HOLD     = 250;
  localparam int SETTLE_CYCLES = 60;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  int                    fault_count;
  int                    due_count;
  bit                    idle_on   = 1'b1;
  int                    quiet_cycles = 0;
  logic [RAW_BITS-1:0]   stick_level [STICK_FIELDS];

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  stick_average_and_channel_scale_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  stick_average_and_channel_scale_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fault_count (fault_count),
    .due_count   (due_count)
  );

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic in_item_t uniform_scan(input logic [RAW_BITS-1:0] sample,
                                            input logic sw_one, input logic sw_two);
    return '{sample, sample, sample, sample, sample, sw_one, sw_two};
  endfunction

  function automatic in_item_t random_scan(input bit steady);
    logic [RAW_BITS-1:0] s [STICK_FIELDS];
    for (int k = 0; k < STICK_FIELDS; k++) begin
      if (steady) begin
        s[k] = stick_level[k];
      end else begin
        case ($urandom_range(0, 7))
          0:       s[k] = '0;
          1:       s[k] = RAW_BITS'(FULL_SCALE);
          default: s[k] = RAW_BITS'($urandom_range(0, FULL_SCALE));
        endcase
      end
    end
    return '{s[0], s[1], s[2], s[3], s[4], 1'($urandom), 1'($urandom)};
  endfunction

  task automatic push_scan(input in_item_t scan);
    int gap;
    gap = idle_on ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= scan;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (due_count != 0);
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_ranges(input logic [CFG_DATA_W-1:0] adc_lo, input logic [CFG_DATA_W-1:0] adc_hi,
                            input logic [CFG_DATA_W-1:0] chan_lo,
                            input logic [CFG_DATA_W-1:0] chan_hi);
    write_reg(CFG_ADC_MIN, adc_lo);
    write_reg(CFG_ADC_MAX, adc_hi);
    write_reg(CFG_CHAN_MIN, chan_lo);
    write_reg(CFG_CHAN_MAX, chan_hi);
    write_reg(CFG_IDX_W'($urandom_range(int'(CFG_CHAN_MAX) + 1, (1 << CFG_IDX_W) - 1)),
              CFG_DATA_W'($urandom));
  endtask

  initial begin : result_sink
    int hold;
    int taken;
    taken = 0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (taken == 150 || taken == 500) begin
        hold = LONG_HOLD;
      end else begin
        hold = idle_on ? $urandom_range(0, MAX_GAP) : 0;
      end
      if (hold > 0) out_stall <= 1'b1;
      @(negedge clk);
      while (!out_valid) @(negedge clk);
      if (hold > 0) begin
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      @(posedge clk);
      taken++;
    end
  end

  initial begin : stimulus
    int p;
    int n;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    push_scan(uniform_scan('0, 1'b0, 1'b0));
    for (n = 0; n < WINDOW_LEN_DEF; n++) push_scan(uniform_scan(RAW_BITS'(FULL_SCALE), 1'b1, 1'b1));
    push_scan(uniform_scan(12'hAAA, 1'b1, 1'b0));
    push_scan(uniform_scan(12'h555, 1'b0, 1'b1));
    push_scan('{12'hFFF, 12'h000, 12'h800, 12'h001, 12'h7FF, 1'b1, 1'b0});
    wait_drained();

    // Channel range inverted; chan_min is written with its upper bit set.
    set_ranges('0, 12'hFFF, 12'hFFF, '0);
    push_scan(uniform_scan(12'hFFF, 1'b1, 1'b0));
    push_scan(uniform_scan(12'h000, 1'b0, 1'b1));
    push_scan(uniform_scan(12'hAAA, 1'b1, 1'b1));
    push_scan(uniform_scan(12'h555, 1'b0, 1'b0));
    wait_drained();

    // Converter range inverted, full channel range.
    set_ranges(12'hFFF, '0, '0, 12'hFFF);
    push_scan(uniform_scan(12'hFFF, 1'b1, 1'b0));
    push_scan(uniform_scan(12'h000, 1'b0, 1'b1));
    push_scan(uniform_scan(12'h123, 1'b1, 1'b1));
    push_scan(uniform_scan(12'hEDC, 1'b0, 1'b0));
    wait_drained();

    for (p = 0; p < PHASES; p++) begin
      case (p)
        0:       set_ranges('0, 12'hFFF, '0, 12'h7FF);
        1:       set_ranges(12'd2048, 12'd2048, 12'd1000, 12'd1000);
        2:       set_ranges(ADC_MIN_RST, ADC_MAX_RST, CFG_DATA_W'(CHAN_MIN_RST),
                            CFG_DATA_W'(CHAN_MAX_RST));
        default: set_ranges(CFG_DATA_W'($urandom_range(0, FULL_SCALE)),
                            CFG_DATA_W'($urandom_range(0, FULL_SCALE)),
                            CFG_DATA_W'($urandom_range(0, FULL_SCALE)),
                            CFG_DATA_W'($urandom_range(0, FULL_SCALE)));
      endcase
      idle_on = (p % 3 != 2);
      for (int k = 0; k < STICK_FIELDS; k++) begin
        case ($urandom_range(0, 2))
          0:       stick_level[k] = '0;
          1:       stick_level[k] = RAW_BITS'(FULL_SCALE);
          default: stick_level[k] = RAW_BITS'($urandom_range(0, FULL_SCALE));
        endcase
      end
      for (n = 0; n < PHASE_SCANS; n++) push_scan(random_scan(n < STEADY_SCANS));
      wait_drained();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fault_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
